// File: src/virtual_time_group_scheduler_top_assert.svh
// assertion macros for the virtual time group scheduler
`ifndef VIRTUAL_TIME_GROUP_SCHEDULER_TOP_ASSERT_SVH
`define VIRTUAL_TIME_GROUP_SCHEDULER_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define VTGS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define VTGS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: src/vtgs_pkg.sv
// shared types and constants of the virtual time group scheduler
package vtgs_pkg;
    typedef enum logic [1:0] {
        OP_SET_SHARE = 2'd0,
        OP_ENQUEUE   = 2'd1,
        OP_TICK      = 2'd2,
        OP_CLEAR     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    localparam int VT_BITS    = 48;
    localparam int SHARE_BITS = 17;
    localparam int TIME_BITS  = 16;
    localparam int DIV_BITS   = 48;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [1:0]            core;
        logic [2:0]            group;
        logic [SHARE_BITS-1:0] share;
        logic [15:0]           proc_id;
        logic [TIME_BITS-1:0]  run_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] next_process;
        logic [2:0]  next_group;
        logic        run_valid;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CHARGE,
        S_REQ,
        S_SCAN,
        S_PICK,
        S_POP,
        S_CLR,
        S_CREQ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

// File: src/vtgs_if.sv
// valid/ready channel interface
interface vtgs_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/vtgs_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module vtgs_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [vtgs_pkg::DIV_BITS-1:0]           dividend,
    input  logic [vtgs_pkg::SHARE_BITS-1:0]         divisor,
    output vtgs_pkg::div_ctl_t                      ctl,
    output logic [vtgs_pkg::DIV_BITS-1:0]           quotient
);
    localparam int CNT_BITS = $clog2(vtgs_pkg::DIV_BITS + 1);
    logic [vtgs_pkg::DIV_BITS-1:0]   quo_reg;
    logic [vtgs_pkg::SHARE_BITS:0]   rem_reg;
    logic [vtgs_pkg::SHARE_BITS-1:0] dvs_reg;
    logic [CNT_BITS-1:0]             cnt_reg;
    logic                            busy_reg;
    logic [vtgs_pkg::SHARE_BITS+1:0] trial;
    logic [vtgs_pkg::SHARE_BITS:0]   shifted;

    assign shifted = {rem_reg[vtgs_pkg::SHARE_BITS-1:0], quo_reg[vtgs_pkg::DIV_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(vtgs_pkg::DIV_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[vtgs_pkg::SHARE_BITS+1])
            begin
                rem_reg <= trial[vtgs_pkg::SHARE_BITS:0];
                quo_reg <= {quo_reg[vtgs_pkg::DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[vtgs_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign quotient  = quo_reg;
endmodule

// File: src/virtual_time_group_scheduler_top.sv
// top level of the virtual time group scheduler
//
//  channel | dir | payload                                      | transfer
//  in_ch   | in  | opcode core group share proc_id run_ticks    | valid & ready
//  out_ch  | out | status next_process next_group run_valid     | valid & ready
//
// set share and enqueue: states DECODE and DONE, then the result is valid
// tick: DECODE, DIV, CHARGE for the 48-step serial divide and write-back when the
//   running share is nonzero, REQ, SCAN of each group, PICK, POP if picked, DONE
// clear shares: CLR steps through each share entry, then CREQ requeues per core
// reset is asynchronous; after reset all shares and virtual times read zero
// in_ch.ready stays low until the result transfers; out_ch stalls hold the result
module virtual_time_group_scheduler_top #(
    parameter int CORE_COUNT   = 4,
    parameter int GROUP_COUNT  = 8,
    parameter int QUEUE_DEPTH  = 32,
    parameter int PROCESS_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    vtgs_if.sink   in_ch,
    vtgs_if.source out_ch
);
    localparam int CB  = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int GB  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int QB  = $clog2(QUEUE_DEPTH);
    localparam int NB  = $clog2(QUEUE_DEPTH + 1);
    localparam int TB  = (CORE_COUNT * GROUP_COUNT > 1) ? $clog2(CORE_COUNT * GROUP_COUNT) : 1;
    localparam int TN  = CORE_COUNT * GROUP_COUNT;
    localparam int VB  = vtgs_pkg::VT_BITS;
    localparam int SB  = vtgs_pkg::SHARE_BITS;
    localparam int GCB = $clog2(GROUP_COUNT + 1);
    localparam int CCB = $clog2(CORE_COUNT + 1);
    localparam int QN  = GROUP_COUNT * QUEUE_DEPTH;
    localparam int QAB = $clog2(QN);
    localparam logic [VB-1:0] VT_MAX = {VB{1'b1}};

    // share and virtual time tables, one entry per core and group
    logic [SB-1:0] share_mem [TN];
    logic [VB-1:0] vt_mem [TN];
    logic [TN-1:0] tv_reg;  // entry written since the last clear
    // shared process queue storage
    logic [PROCESS_BITS-1:0] q_mem [QN];
    logic [QB-1:0] front_reg [GROUP_COUNT];
    logic [NB-1:0] count_reg [GROUP_COUNT];
    logic [PROCESS_BITS-1:0] rproc_reg [CORE_COUNT];
    logic [GB-1:0] rgrp_reg [CORE_COUNT];
    logic [CORE_COUNT-1:0] rflag_reg;

    vtgs_pkg::state_t state_reg, state_next;
    vtgs_pkg::in_item_t item_reg;
    vtgs_pkg::out_item_t res_reg;
    logic out_valid_reg;

    // table read port, registered
    logic [TB-1:0] taddr;
    logic [SB-1:0] sh_rd_reg;
    logic [VB-1:0] vt_rd_reg;
    logic          tvalid_rd_reg;
    logic [SB-1:0] sh_rd;
    logic [VB-1:0] vt_rd;

    // scan and requeue bookkeeping
    logic [GCB-1:0] gi_reg;
    logic [CCB-1:0] ci_reg;
    logic [TB:0]    ti_reg;
    logic           found_reg;
    logic [GB-1:0]  best_reg;
    logic [VB-1:0]  best_vt_reg;
    logic           scan_ph_reg;
    logic [1:0]     st_reg;
    logic [PROCESS_BITS-1:0] q_rd_reg;

    // divider
    logic                 div_start;
    vtgs_pkg::div_ctl_t   div_ctl;
    logic [VB-1:0]        quo;
    logic [VB:0]          vsum;

    logic [CB-1:0] core_i;
    logic [GB-1:0] grp_i;
    logic          core_ok, grp_ok;

    assign core_ok = 32'(item_reg.core) < CORE_COUNT;
    assign grp_ok  = 32'(item_reg.group) < GROUP_COUNT;
    assign core_i  = CB'(item_reg.core);
    assign grp_i   = GB'(item_reg.group);

    assign sh_rd = tvalid_rd_reg ? sh_rd_reg : '0;
    assign vt_rd = tvalid_rd_reg ? vt_rd_reg : '0;

    vtgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({item_reg.run_ticks, 32'd0}),
        .divisor  (sh_rd),
        .ctl      (div_ctl),
        .quotient (quo)
    );

    assign in_ch.ready  = (state_reg == vtgs_pkg::S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    // running group index of the addressed core
    logic [GB-1:0] rg;
    logic          rf;
    assign rg = rgrp_reg[core_i];
    assign rf = rflag_reg[core_i];

    // requeue helper for the current requeue core
    logic [CB-1:0] rq_core;
    logic [GB-1:0] rq_g;
    logic [31:0]   rq_sum;
    logic [QB-1:0] rq_slot;
    assign rq_core = (state_reg == vtgs_pkg::S_CREQ) ? CB'(ci_reg) : core_i;
    assign rq_g    = rgrp_reg[rq_core];
    // back slot wraps at most once
    assign rq_sum  = 32'(front_reg[rq_g]) + 32'(count_reg[rq_g]);
    assign rq_slot = (rq_sum >= 32'(QUEUE_DEPTH)) ? QB'(rq_sum - 32'(QUEUE_DEPTH))
                                                  : QB'(rq_sum);

    assign vsum = {1'b0, vt_rd} + {1'b0, quo};

    always_comb
    begin
        taddr = '0;
        unique case (state_reg)
            vtgs_pkg::S_DECODE: taddr = TB'(32'(core_i) * GROUP_COUNT + 32'(rg));
            vtgs_pkg::S_SCAN:   taddr = TB'(32'(core_i) * GROUP_COUNT + 32'(gi_reg));
            default:            taddr = TB'(32'(core_i) * GROUP_COUNT + 32'(rg));
        endcase
    end

    always_ff @(posedge clk)
    begin
        sh_rd_reg <= share_mem[taddr];
        vt_rd_reg <= vt_mem[taddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_rd_reg <= 1'b0;
        end
        else
        begin
            tvalid_rd_reg <= tv_reg[taddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtgs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            vtgs_pkg::S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = vtgs_pkg::S_DECODE;
                end
            end
            vtgs_pkg::S_DECODE:
            begin
                unique case (vtgs_pkg::opcode_t'(item_reg.opcode))
                    vtgs_pkg::OP_TICK:
                    begin
                        if (!core_ok)
                        begin
                            state_next = vtgs_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = vtgs_pkg::S_DIV;
                        end
                    end
                    vtgs_pkg::OP_CLEAR: state_next = vtgs_pkg::S_CLR;
                    default:            state_next = vtgs_pkg::S_DONE;
                endcase
            end
            vtgs_pkg::S_DIV:
            begin
                // table data for the running group is now registered
                if (rf && (32'(rg) < GROUP_COUNT) && (sh_rd != '0))
                begin
                    div_start  = 1'b1;
                    state_next = vtgs_pkg::S_CHARGE;
                end
                else
                begin
                    state_next = vtgs_pkg::S_REQ;
                end
            end
            vtgs_pkg::S_CHARGE:
            begin
                if (!div_ctl.busy && !div_ctl.start)
                begin
                    state_next = vtgs_pkg::S_REQ;
                end
            end
            vtgs_pkg::S_REQ:  state_next = vtgs_pkg::S_SCAN;
            vtgs_pkg::S_SCAN:
            begin
                if (scan_ph_reg && (32'(gi_reg) == GROUP_COUNT - 1))
                begin
                    state_next = vtgs_pkg::S_PICK;
                end
            end
            vtgs_pkg::S_PICK:
            begin
                if (found_reg && count_reg[best_reg] != '0)
                begin
                    state_next = vtgs_pkg::S_POP;
                end
                else
                begin
                    state_next = vtgs_pkg::S_DONE;
                end
            end
            vtgs_pkg::S_POP:  state_next = vtgs_pkg::S_DONE;
            vtgs_pkg::S_CLR:
            begin
                if (32'(ti_reg) == TN - 1)
                begin
                    state_next = vtgs_pkg::S_CREQ;
                end
            end
            vtgs_pkg::S_CREQ:
            begin
                if (32'(ci_reg) == CORE_COUNT - 1)
                begin
                    state_next = vtgs_pkg::S_DONE;
                end
            end
            vtgs_pkg::S_DONE: state_next = vtgs_pkg::S_IDLE;
            default:          state_next = vtgs_pkg::S_IDLE;
        endcase
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (state_reg == vtgs_pkg::S_DECODE
            && vtgs_pkg::opcode_t'(item_reg.opcode) == vtgs_pkg::OP_SET_SHARE
            && core_ok && grp_ok)
        begin
            share_mem[TB'(32'(core_i) * GROUP_COUNT + 32'(grp_i))] <= item_reg.share;
            vt_mem[TB'(32'(core_i) * GROUP_COUNT + 32'(grp_i))]    <= '0;
        end
        else if (state_reg == vtgs_pkg::S_CHARGE && !div_ctl.busy && !div_ctl.start)
        begin
            share_mem[taddr] <= sh_rd;
            vt_mem[taddr]    <= vsum[VB] ? VT_MAX : vsum[VB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else if (state_reg == vtgs_pkg::S_DECODE
                 && vtgs_pkg::opcode_t'(item_reg.opcode) == vtgs_pkg::OP_SET_SHARE
                 && core_ok && grp_ok)
        begin
            tv_reg[TB'(32'(core_i) * GROUP_COUNT + 32'(grp_i))] <= 1'b1;
        end
        else if (state_reg == vtgs_pkg::S_CLR)
        begin
            tv_reg[TB'(ti_reg)] <= 1'b0;
        end
    end

    // queue store: write at push, read registered
    logic          q_we;
    logic [QAB-1:0] q_waddr;
    logic [PROCESS_BITS-1:0] q_wdata;
    logic [QB-1:0] enq_slot;
    // front moves back by one, wrapping to the last slot
    assign enq_slot = (front_reg[grp_i] == '0) ? QB'(QUEUE_DEPTH - 1)
                                               : front_reg[grp_i] - 1'b1;

    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = rproc_reg[rq_core];
        if (state_reg == vtgs_pkg::S_DECODE
            && vtgs_pkg::opcode_t'(item_reg.opcode) == vtgs_pkg::OP_ENQUEUE
            && grp_ok && 32'(count_reg[grp_i]) < QUEUE_DEPTH)
        begin
            q_we    = 1'b1;
            q_waddr = QAB'(32'(grp_i) * QUEUE_DEPTH + 32'(enq_slot));
            q_wdata = PROCESS_BITS'(item_reg.proc_id);
        end
        else if ((state_reg == vtgs_pkg::S_REQ || state_reg == vtgs_pkg::S_CREQ)
                 && rflag_reg[rq_core] && 32'(rq_g) < GROUP_COUNT
                 && 32'(count_reg[rq_g]) < QUEUE_DEPTH)
        begin
            q_we    = 1'b1;
            q_waddr = QAB'(32'(rq_g) * QUEUE_DEPTH + 32'(rq_slot));
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[QAB'(32'(best_reg) * QUEUE_DEPTH + 32'(front_reg[best_reg]))];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rflag_reg     <= '0;
            gi_reg        <= '0;
            ci_reg        <= '0;
            ti_reg        <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            scan_ph_reg   <= 1'b0;
            st_reg        <= '0;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                front_reg[g] <= '0;
                count_reg[g] <= '0;
            end
            for (int c = 0; c < CORE_COUNT; c++)
            begin
                rproc_reg[c] <= '0;
                rgrp_reg[c]  <= '0;
            end
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                vtgs_pkg::S_IDLE:
                begin
                    st_reg      <= vtgs_pkg::ST_OK;
                    gi_reg      <= '0;
                    ci_reg      <= '0;
                    ti_reg      <= '0;
                    found_reg   <= 1'b0;
                    best_reg    <= '0;
                    scan_ph_reg <= 1'b0;
                end
                vtgs_pkg::S_DECODE:
                begin
                    unique case (vtgs_pkg::opcode_t'(item_reg.opcode))
                        vtgs_pkg::OP_ENQUEUE:
                        begin
                            if (q_we)
                            begin
                                front_reg[grp_i] <= enq_slot;
                                count_reg[grp_i] <= count_reg[grp_i] + 1'b1;
                            end
                            else
                            begin
                                st_reg <= vtgs_pkg::ST_FULL;
                            end
                        end
                        vtgs_pkg::OP_TICK:
                        begin
                            if (!core_ok)
                            begin
                                st_reg <= vtgs_pkg::ST_NONE;
                            end
                        end
                        default: ;
                    endcase
                end
                vtgs_pkg::S_REQ, vtgs_pkg::S_CREQ:
                begin
                    if (rflag_reg[rq_core])
                    begin
                        if (q_we)
                        begin
                            count_reg[rq_g] <= count_reg[rq_g] + 1'b1;
                        end
                        else
                        begin
                            st_reg <= vtgs_pkg::ST_FULL;
                        end
                    end
                    rflag_reg[rq_core] <= 1'b0;
                    if (state_reg == vtgs_pkg::S_CREQ)
                    begin
                        ci_reg <= ci_reg + 1'b1;
                    end
                end
                vtgs_pkg::S_SCAN:
                begin
                    // phase 0 issues the read, phase 1 compares it
                    scan_ph_reg <= !scan_ph_reg;
                    if (scan_ph_reg)
                    begin
                        if (sh_rd != '0 && (!found_reg || vt_rd < best_vt_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= GB'(gi_reg);
                        end
                        gi_reg <= gi_reg + 1'b1;
                    end
                end
                vtgs_pkg::S_PICK:
                begin
                    if (!found_reg)
                    begin
                        st_reg <= vtgs_pkg::ST_NONE;
                    end
                    else if (count_reg[best_reg] == '0)
                    begin
                        st_reg <= vtgs_pkg::ST_EMPTY;
                    end
                end
                vtgs_pkg::S_POP:
                begin
                    front_reg[best_reg] <= (32'(front_reg[best_reg]) == QUEUE_DEPTH - 1)
                                           ? '0 : front_reg[best_reg] + 1'b1;
                    count_reg[best_reg] <= count_reg[best_reg] - 1'b1;
                    rproc_reg[core_i]   <= q_rd_reg;
                    rgrp_reg[core_i]    <= best_reg;
                    rflag_reg[core_i]   <= 1'b1;
                end
                vtgs_pkg::S_CLR:
                begin
                    ti_reg <= ti_reg + 1'b1;
                end
                vtgs_pkg::S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.data;
        end
        if (state_reg == vtgs_pkg::S_SCAN && scan_ph_reg
            && sh_rd != '0 && (!found_reg || vt_rd < best_vt_reg))
        begin
            best_vt_reg <= vt_rd;
        end
        if (state_reg == vtgs_pkg::S_DONE)
        begin
            res_reg.status <= st_reg;
        end
        if (state_reg == vtgs_pkg::S_POP)
        begin
            res_reg.run_valid    <= 1'b1;
            res_reg.next_process <= 16'(q_rd_reg);
            res_reg.next_group   <= 3'(best_reg);
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            // the previous result has already transferred here
            res_reg.run_valid    <= 1'b0;
            res_reg.next_process <= '0;
            res_reg.next_group   <= '0;
        end
    end
endmodule

// File: src/vtgs_checker.sv
// port-level assertions for the virtual time group scheduler
`include "virtual_time_group_scheduler_top_assert.svh"
module vtgs_assert_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_run_valid,
    input logic [1:0] out_status
);
    `VTGS_ASSERT_IMP(a_busy_no_accept, out_valid, !in_ready)
    `VTGS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
    `VTGS_ASSERT_IMP(a_run_ok, out_valid && out_run_valid, out_status < vtgs_pkg::ST_NONE)
    `VTGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind virtual_time_group_scheduler_top vtgs_assert_checker u_vtgs_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_run_valid (out_ch.data.run_valid),
    .out_status    (out_ch.data.status)
);
